>>> hw/rtl/mhba_pkg.sv
// Shared types and constants of the multi-heap bump descriptor allocator.
package mhba_pkg;

	// Field widths
	localparam int ADDR_W   = 48;
	localparam int STRIDE_W = 9;
	localparam int CAP_W    = 11;
	localparam int ARENA_W  = 3;
	localparam int OUTC_W   = 2;
	localparam int CFG_W    = 64;
	localparam int PADDR_W  = 5;

	// Request kinds (tuser on the input side)
	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	// Result outcome codes
	localparam logic [OUTC_W-1:0] OUT_OK        = 2'd0;
	localparam logic [OUTC_W-1:0] OUT_EXHAUSTED = 2'd1;
	localparam logic [OUTC_W-1:0] OUT_STRAY     = 2'd2;

	// Register indexes (byte address is 8 times the index)
	localparam logic [1:0] REG_STRIDE   = 2'd0;
	localparam logic [1:0] REG_CAPACITY = 2'd1;
	localparam logic [1:0] REG_CPU_BASE = 2'd2;
	localparam logic [1:0] REG_GPU_BASE = 2'd3;

	// Register reset values
	localparam logic [STRIDE_W-1:0] STRIDE_RST   = 9'd32;
	localparam logic [CAP_W-1:0]    CAPACITY_RST = 11'd1024;

	// One result item
	typedef struct packed {
		logic [OUTC_W-1:0]  outcome;
		logic [ARENA_W-1:0] arena_number;
		logic [ADDR_W-1:0]  gpu_address;
		logic [ADDR_W-1:0]  cpu_address;
	} result_t;

endpackage

>>> hw/rtl/mhba_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mhba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [AW-1:0]            waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [AW-1:0]            raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> hw/rtl/multi_heap_bump_descriptor_allocator.sv
// Top level of the multi-heap bump descriptor allocator.
//
//  channel  | direction | handshake                   | contents
//  ---------+-----------+-----------------------------+-------------------------------------
//  s_*      | in        | s_tvalid / s_tready         | tuser: req_type; tdata: release_address
//  m_*      | out       | m_tvalid / m_tready         | tdata: cpu, gpu, arena_number, outcome
//  APB      | in        | psel, penable, pwrite       | 4 registers at paddr 0, 8, 16, 24
//
// Each request scans the open arenas; the scan reads one counter entry per pass through
// the read and check states, and one shared multiplier forms the span, the arena offset
// and the slot offset.
// Reset clears the open-arena count, so the counter RAM needs no clearing pass.
// A finished result waits in the output register; the next request is taken meanwhile
// and waits in its last state only while the output register is still full.
module multi_heap_bump_descriptor_allocator
	import mhba_pkg::*;
#(
	parameter int MAX_HEAPS       = 8,
	parameter int MAX_ARENA_SLOTS = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	// Request stream
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [47:0]        s_tdata,   // [47:0] release_address
	input  logic               s_tuser,   // [0] req_type
	// Result stream
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [103:0]       m_tdata,   // [47:0] cpu_address, [95:48] gpu_address,
	                                      // [98:96] arena_number, [100:99] outcome, zero above
	// Configuration
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [CFG_W-1:0]   pwdata,
	output logic [CFG_W-1:0]   prdata,
	output logic               pready
);
	localparam int CW = $clog2(MAX_ARENA_SLOTS + 1);             // slot count width
	localparam int HW = $clog2(MAX_HEAPS + 1);                   // arena count width
	localparam int AW = (MAX_HEAPS > 1) ? $clog2(MAX_HEAPS) : 1; // arena index width
	localparam int MW = (CW > HW) ? CW : HW;                     // multiplier operand a
	localparam int SW = MW + STRIDE_W;                           // span width
	localparam int PW = MW + SW;                                 // product width

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_SPAN = 4'd1;
	localparam logic [3:0] S_RD   = 4'd2;
	localparam logic [3:0] S_CHK  = 4'd3;
	localparam logic [3:0] S_OFF1 = 4'd4;
	localparam logic [3:0] S_OFF2 = 4'd5;
	localparam logic [3:0] S_SUM  = 4'd6;
	localparam logic [3:0] S_ADDR = 4'd7;
	localparam logic [3:0] S_OUT  = 4'd8;

	logic [3:0]          state_q;

	// Configuration registers
	logic [STRIDE_W-1:0] stride_q;
	logic [CAP_W-1:0]    cap_q;
	logic [ADDR_W-1:0]   cpu_base_q;
	logic [ADDR_W-1:0]   gpu_base_q;

	// Request and work registers
	logic                kind_q;
	logic [ADDR_W-1:0]   addr_q;
	logic [ADDR_W-1:0]   diff_q;
	logic [SW-1:0]       span_q;
	logic [HW-1:0]       open_q;
	logic [HW-1:0]       idx_q;
	logic [CW-1:0]       hand_q;
	logic [CW-1:0]       give_q;
	logic [PW-1:0]       prod_q;
	logic [PW-1:0]       prod2_q;
	logic [ADDR_W-1:0]   off_q;
	result_t             res_q;
	result_t             out_q;
	logic                out_valid_q;

	logic [CW-1:0]       cap_eff;
	logic [MW-1:0]       mul_a;
	logic [SW-1:0]       mul_b;
	logic [PW-1:0]       mul_p;
	logic                cfg_wr;
	logic                in_xfer;
	logic                out_free;
	logic [ADDR_W-1:0]   rel;
	logic                ram_we;
	logic                ram_re;
	logic [2*CW-1:0]     ram_wdata;
	logic [2*CW-1:0]     ram_rdata;
	logic [CW-1:0]       rd_hand;
	logic [CW-1:0]       rd_give;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign s_tready = (state_q == S_IDLE);
	assign in_xfer  = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'd0, out_q};

	// Clamp capacity to 1..MAX_ARENA_SLOTS
	always_comb begin
		if (cap_q == '0) begin
			cap_eff = CW'(1);
		end else if (32'(cap_q) > 32'(MAX_ARENA_SLOTS)) begin
			cap_eff = CW'(MAX_ARENA_SLOTS);
		end else begin
			cap_eff = CW'(cap_q);
		end
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stride_q   <= STRIDE_RST;
			cap_q      <= CAPACITY_RST;
			cpu_base_q <= '0;
			gpu_base_q <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[4:3])
				REG_STRIDE:   stride_q   <= pwdata[STRIDE_W-1:0];
				REG_CAPACITY: cap_q      <= pwdata[CAP_W-1:0];
				REG_CPU_BASE: cpu_base_q <= pwdata[ADDR_W-1:0];
				REG_GPU_BASE: gpu_base_q <= pwdata[ADDR_W-1:0];
				default: ;
			endcase
		end
	end

	// Configuration reads
	always_comb begin
		unique case (paddr[4:3])
			REG_STRIDE:   prdata = CFG_W'(stride_q);
			REG_CAPACITY: prdata = CFG_W'(cap_q);
			REG_CPU_BASE: prdata = CFG_W'(cpu_base_q);
			REG_GPU_BASE: prdata = CFG_W'(gpu_base_q);
			default:      prdata = '0;
		endcase
	end

	// Select operands of the shared multiplier
	always_comb begin
		unique case (state_q)
			S_SPAN: begin
				mul_a = MW'(cap_eff);
				mul_b = SW'(stride_q);
			end
			S_OFF2: begin
				mul_a = MW'(hand_q);
				mul_b = SW'(stride_q);
			end
			default: begin
				mul_a = MW'(idx_q);
				mul_b = span_q;
			end
		endcase
	end

	assign mul_p = PW'(mul_a) * PW'(mul_b);

	// Offset of the request address inside the arena under test
	assign rel = diff_q - ADDR_W'(prod_q);

	// Counter RAM: {handed_out, given_back} per arena
	assign rd_hand = ram_rdata[2*CW-1:CW];
	assign rd_give = ram_rdata[CW-1:0];
	assign ram_re  = (state_q == S_RD) && (idx_q != open_q);

	always_comb begin
		ram_we    = 1'b0;
		ram_wdata = {hand_q + CW'(1), give_q};
		if (state_q == S_ADDR) begin
			ram_we = 1'b1;
		end else if (state_q == S_CHK && kind_q == REQ_FREE && rel < ADDR_W'(span_q)
		             && rd_give < rd_hand) begin
			ram_we = 1'b1;
			if (rd_give + CW'(1) == rd_hand) begin
				ram_wdata = '0;
			end else begin
				ram_wdata = {rd_hand, rd_give + CW'(1)};
			end
		end
	end

	mhba_ram #(
		.WIDTH (2 * CW),
		.DEPTH (MAX_HEAPS)
	) u_cnt_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (idx_q[AW-1:0]),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (idx_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	// Sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			open_q      <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// Load a finished result or drop the one just transferred
			if (state_q == S_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						idx_q   <= '0;
						state_q <= S_SPAN;
					end
				end
				S_SPAN: state_q <= S_RD;
				S_RD: begin
					if (idx_q == open_q) begin
						if (kind_q == REQ_ALLOC && open_q != HW'(MAX_HEAPS)) begin
							open_q  <= open_q + HW'(1);
							state_q <= S_OFF1;
						end else begin
							state_q <= S_OUT;
						end
					end else begin
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					if (kind_q == REQ_ALLOC) begin
						if (rd_hand < cap_eff) begin
							state_q <= S_OFF2;
						end else begin
							idx_q   <= idx_q + HW'(1);
							state_q <= S_RD;
						end
					end else if (rel < ADDR_W'(span_q)) begin
						state_q <= S_OUT;
					end else begin
						idx_q   <= idx_q + HW'(1);
						state_q <= S_RD;
					end
				end
				S_OFF1: state_q <= S_OFF2;
				S_OFF2: state_q <= S_SUM;
				S_SUM:  state_q <= S_ADDR;
				S_ADDR: state_q <= S_OUT;
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Sequencer datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_xfer) begin
					kind_q <= s_tuser;
					addr_q <= s_tdata[ADDR_W-1:0];
				end
			end
			S_SPAN: begin
				span_q <= mul_p[SW-1:0];
				diff_q <= addr_q - cpu_base_q;
			end
			S_RD: begin
				prod_q <= mul_p;
				if (idx_q == open_q) begin
					// No open arena serves: open a new one or report
					hand_q <= '0;
					give_q <= '0;
					res_q  <= '{outcome: (kind_q == REQ_ALLOC) ? OUT_EXHAUSTED : OUT_STRAY,
					           arena_number: '0, gpu_address: '0, cpu_address: '0};
				end
			end
			S_CHK: begin
				hand_q <= rd_hand;
				give_q <= rd_give;
				if (kind_q == REQ_FREE && rel < ADDR_W'(span_q)) begin
					if (rd_give < rd_hand) begin
						res_q <= '{outcome: OUT_OK, arena_number: ARENA_W'(idx_q),
						           gpu_address: '0, cpu_address: '0};
					end else begin
						res_q <= '{outcome: OUT_STRAY, arena_number: '0,
						           gpu_address: '0, cpu_address: '0};
					end
				end
			end
			S_OFF1: prod_q <= mul_p;
			S_OFF2: prod2_q <= mul_p;
			S_SUM:  off_q <= ADDR_W'(prod_q) + ADDR_W'(prod2_q);
			S_ADDR: begin
				res_q <= '{outcome: OUT_OK, arena_number: ARENA_W'(idx_q),
				           gpu_address: gpu_base_q + off_q, cpu_address: cpu_base_q + off_q};
			end
			S_OUT: begin
				if (out_free) begin
					out_q <= res_q;
				end
			end
			default: ;
		endcase
	end

	// Assertions
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> !s_tready)
		else $error("request taken while a request is in progress");

	a_open_bound: assert property (@(posedge clk) disable iff (!arst_n)
		open_q <= HW'(MAX_HEAPS) && idx_q <= open_q)
		else $error("arena count or scan index out of range");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.outcome != OUT_OK) |->
		(out_q.cpu_address == '0 && out_q.gpu_address == '0 && out_q.arena_number == '0))
		else $error("failed request carries nonzero fields");

	a_ram_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == S_ADDR || (state_q == S_CHK && kind_q == REQ_FREE)))
		else $error("counter write outside an update step");

endmodule

>>> dv/testbench.sv
// Self-checking testbench for the multi-heap bump descriptor allocator.
module testbench;
	import mhba_pkg::*;

	localparam int NUM_ARENAS = 8;
	localparam int SLOT_LIMIT = 1024;
	localparam logic [ADDR_W-1:0] CPU_TOP = 48'hFFFF_FFFF_FDA8;

	typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_style_t;

	// Clock, reset and block ports
	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [47:0]        s_tdata = '0;   // [47:0] release_address
	logic               s_tuser = 1'b0; // [0] req_type
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [103:0]       m_tdata;        // [47:0] cpu, [95:48] gpu, [98:96] arena, [100:99] outcome
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [CFG_W-1:0]   pwdata = '0;
	logic [CFG_W-1:0]   prdata;
	logic               pready;

	// Register shadows and allocator state of the predictor
	logic [STRIDE_W-1:0] cfg_stride = STRIDE_RST;
	logic [CAP_W-1:0]    cfg_capacity = CAPACITY_RST;
	logic [ADDR_W-1:0]   cfg_cpu_base = '0;
	logic [ADDR_W-1:0]   cfg_gpu_base = '0;
	int                  arenas_in_use = 0;
	int                  arena_allocs [NUM_ARENAS];
	int                  arena_frees [NUM_ARENAS];

	// Expected grants and handles known to the stimulus
	result_t           grants_due [$];
	logic [ADDR_W-1:0] live_handles [$];
	logic [ADDR_W-1:0] freed_handles [$];

	// Tallies
	int mismatch_count = 0;
	int results_checked = 0;
	int alloc_sent = 0;
	int free_sent = 0;
	int reg_writes = 0;
	int tally_ok = 0;
	int tally_exhausted = 0;
	int tally_stray = 0;

	// Receiver stall control
	int        hold_request = 0;
	int        hold_left = 0;
	int        rx_segment = 0;
	rx_style_t rx_style = RX_OPEN;
	logic [1:0] rx_tick = '0;

	multi_heap_bump_descriptor_allocator #(
		.MAX_HEAPS(NUM_ARENAS),
		.MAX_ARENA_SLOTS(SLOT_LIMIT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Clamp the capacity register to the slots an arena can hold
	function automatic logic [ADDR_W-1:0] slots_per_arena();
		if (cfg_capacity == 0)
			return 48'd1;
		if (cfg_capacity > SLOT_LIMIT)
			return 48'(SLOT_LIMIT);
		return 48'(cfg_capacity);
	endfunction

	function automatic logic [ADDR_W-1:0] arena_span();
		return slots_per_arena() * 48'(cfg_stride);
	endfunction

	// Work out the grant for one request and advance the arena counters
	function automatic result_t compute_grant(logic kind, logic [ADDR_W-1:0] addr);
		result_t           r;
		logic [ADDR_W-1:0] cap, span, off, base, rel;
		int                pick, i;
		r = '0;
		cap = slots_per_arena();
		span = arena_span();
		if (kind == REQ_ALLOC) begin
			pick = -1;
			for (i = 0; i < arenas_in_use; i++)
				if (pick < 0 && 48'(arena_allocs[i]) < cap)
					pick = i;
			if (pick < 0) begin
				if (arenas_in_use >= NUM_ARENAS) begin
					r.outcome = OUT_EXHAUSTED;
					return r;
				end
				pick = arenas_in_use;
				arenas_in_use++;
				arena_allocs[pick] = 0;
				arena_frees[pick] = 0;
			end
			off = 48'(pick) * span + 48'(arena_allocs[pick]) * 48'(cfg_stride);
			arena_allocs[pick]++;
			r.cpu_address = cfg_cpu_base + off;
			r.gpu_address = cfg_gpu_base + off;
			r.arena_number = ARENA_W'(pick);
			r.outcome = OUT_OK;
			return r;
		end
		r.outcome = OUT_STRAY;
		for (i = 0; i < arenas_in_use; i++) begin
			base = cfg_cpu_base + 48'(i) * span;
			rel = addr - base;
			if (rel < span) begin
				// release with nothing outstanding counts as stray
				if (arena_frees[i] >= arena_allocs[i])
					return r;
				arena_frees[i]++;
				if (arena_frees[i] == arena_allocs[i]) begin
					arena_allocs[i] = 0;
					arena_frees[i] = 0;
				end
				r.outcome = OUT_OK;
				r.arena_number = ARENA_W'(i);
				return r;
			end
		end
		return r;
	endfunction

	function automatic logic [ADDR_W-1:0] random48();
		return 48'({$urandom(), $urandom()});
	endfunction

	// Pick a random outstanding handle and move it to the freed list
	function automatic logic [ADDR_W-1:0] take_live_handle();
		logic [ADDR_W-1:0] a;
		int                idx;
		idx = $urandom_range(0, live_handles.size() - 1);
		a = live_handles[idx];
		live_handles.delete(idx);
		freed_handles.push_back(a);
		if (freed_handles.size() > 64)
			void'(freed_handles.pop_front());
		return a;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] want,
			input logic [63:0] got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("[%0t] mismatch on %s: expected %h got %h", $realtime, what, want, got);
	endtask

	// Compare one result transfer with the oldest expected grant
	task automatic check_result(input logic [103:0] data);
		result_t got, want;
		got = result_t'(data[100:0]);
		results_checked++;
		if (grants_due.size() == 0) begin
			report_mismatch("unexpected result", '0, 64'(data[100:0]));
			return;
		end
		want = grants_due.pop_front();
		if (got.cpu_address !== want.cpu_address)
			report_mismatch("cpu_address", 64'(want.cpu_address), 64'(got.cpu_address));
		if (got.gpu_address !== want.gpu_address)
			report_mismatch("gpu_address", 64'(want.gpu_address), 64'(got.gpu_address));
		if (got.arena_number !== want.arena_number)
			report_mismatch("arena_number", 64'(want.arena_number), 64'(got.arena_number));
		if (got.outcome !== want.outcome)
			report_mismatch("outcome", 64'(want.outcome), 64'(got.outcome));
		if (data[103:101] !== 3'b000)
			report_mismatch("pad bits", '0, 64'(data[103:101]));
	endtask

	// Receiver: check each transfer, then stall on a changing pattern
	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			check_result(m_tdata);
		rx_tick <= rx_tick + 2'd1;
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			if (rx_segment == 0) begin
				rx_style = rx_style_t'($urandom_range(0, 3));
				rx_segment = $urandom_range(10, 150);
			end else begin
				rx_segment--;
			end
			case (rx_style)
				RX_OPEN: m_tready <= 1'b1;
				RX_COIN: m_tready <= ($urandom_range(0, 1) == 1);
				RX_SPARSE: m_tready <= (rx_tick == 2'b00);
				default: m_tready <= ($urandom_range(0, 9) != 0);
			endcase
		end
	end

	// Offer one request and hold it until the transfer; valid stays high afterwards
	task automatic send_request(input logic kind, input logic [ADDR_W-1:0] addr);
		result_t want;
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= addr;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		want = compute_grant(kind, addr);
		grants_due.push_back(want);
		if (kind == REQ_ALLOC) begin
			alloc_sent++;
			if (want.outcome == OUT_OK)
				live_handles.push_back(want.cpu_address);
		end else begin
			free_sent++;
		end
		case (want.outcome)
			OUT_OK: tally_ok++;
			OUT_EXHAUSTED: tally_exhausted++;
			default: tally_stray++;
		endcase
	endtask

	task automatic sender_pause(input int cycles);
		s_tvalid <= 1'b0;
		repeat (cycles)
			@(posedge clk);
	endtask

	// Stop offering and wait for every outstanding grant
	task automatic wait_all_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (grants_due.size() != 0)
			@(posedge clk);
	endtask

	// Register write: setup cycle, then access cycle until pready
	task automatic apb_write(input logic [1:0] idx, input logic [CFG_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		reg_writes++;
		case (idx)
			REG_STRIDE: cfg_stride = value[STRIDE_W-1:0];
			REG_CAPACITY: cfg_capacity = value[CAP_W-1:0];
			REG_CPU_BASE: cfg_cpu_base = value[ADDR_W-1:0];
			default: cfg_gpu_base = value[ADDR_W-1:0];
		endcase
	endtask

	task automatic apply_settings(input logic [CFG_W-1:0] stride, input logic [CFG_W-1:0] cap,
			input logic [CFG_W-1:0] cpu_base, input logic [CFG_W-1:0] gpu_base);
		wait_all_results();
		apb_write(REG_STRIDE, stride);
		apb_write(REG_CAPACITY, cap);
		apb_write(REG_CPU_BASE, cpu_base);
		apb_write(REG_GPU_BASE, gpu_base);
	endtask

	// Reset values: first grants, release, stray and double release
	task automatic test_reset_state();
		send_request(REQ_FREE, 48'd0);
		send_request(REQ_ALLOC, 48'hFFFF_FFFF_FFFF);
		send_request(REQ_ALLOC, 48'd0);
		send_request(REQ_FREE, 48'hFFFF_FFFF_FFFF);
		send_request(REQ_FREE, 48'd32);
		send_request(REQ_FREE, 48'd32);
		send_request(REQ_FREE, 48'd0);
		sender_pause(5);
	endtask

	// Fill every arena, run out, reuse an emptied arena; addresses wrap past the top
	task automatic test_exhaustion_and_wrap();
		wait_all_results();
		apb_write(REG_STRIDE, 64'd256);
		// upper bits above each register width are dropped
		apb_write(REG_CAPACITY, 64'hFFFF_0000_0000_0801);
		apb_write(REG_CPU_BASE, {16'h5A5A, CPU_TOP});
		apb_write(REG_GPU_BASE, 64'hABCD_FFFF_FFFF_FFF0);
		repeat (9)
			send_request(REQ_ALLOC, random48());
		send_request(REQ_FREE, CPU_TOP + 48'd1024);
		send_request(REQ_ALLOC, 48'd0);
		send_request(REQ_FREE, CPU_TOP + 48'd1023);
		send_request(REQ_FREE, CPU_TOP + 48'd2048);
		send_request(REQ_FREE, CPU_TOP + 48'd1023);
		live_handles.delete();
	endtask

	// Zero stride: slots share one address and no release can match
	task automatic test_zero_stride();
		wait_all_results();
		apb_write(REG_STRIDE, 64'd0);
		apb_write(REG_CAPACITY, 64'd4);
		send_request(REQ_ALLOC, 48'h0);
		send_request(REQ_ALLOC, 48'h1);
		send_request(REQ_FREE, CPU_TOP);
		live_handles.delete();
	endtask

	// Mostly well-formed allocate/release traffic with some noise, in bursts
	task automatic random_phase(input int count, input int alloc_pct, input bit release_all);
		int                n, burst, roll, pick;
		logic [ADDR_W-1:0] addr;
		n = 0;
		while (n < count) begin
			burst = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
			repeat (burst) begin
				roll = $urandom_range(0, 99);
				if (roll < alloc_pct) begin
					send_request(REQ_ALLOC, random48());
				end else if (roll < 92 && live_handles.size() > 0) begin
					send_request(REQ_FREE, take_live_handle());
				end else begin
					pick = $urandom_range(0, 3);
					if (pick == 0 || freed_handles.size() == 0)
						addr = random48();
					else if (pick == 1)
						addr = freed_handles[$urandom_range(0, freed_handles.size() - 1)];
					else if (pick == 2)
						addr = cfg_cpu_base + 48'($urandom_range(0, 9 * arena_span()));
					else
						addr = cfg_cpu_base - 48'($urandom_range(1, 64));
					send_request(REQ_FREE, addr);
				end
				n++;
			end
			// gaps of all sizes, sometimes none, sometimes a full drain
			if ($urandom_range(0, 24) == 0)
				wait_all_results();
			else if ($urandom_range(0, 3) != 0)
				sender_pause($urandom_range(1, 25));
		end
		if (release_all) begin
			while (live_handles.size() > 0) begin
				send_request(REQ_FREE, take_live_handle());
				if ($urandom_range(0, 5) == 0)
					sender_pause($urandom_range(1, 10));
			end
		end
	endtask

	// Sweep register settings, extremes included
	task automatic test_random_settings();
		int                k;
		logic [CFG_W-1:0]  cap;
		apply_settings(64'd1, 64'd1, 64'd0, 64'd0);
		random_phase(60, 55, 1'b1);
		apply_settings(64'd256, 64'd1024, 64'(random48()), 64'(random48()));
		random_phase(70, 60, 1'b1);
		apply_settings(64'h1FF, 64'h7FF, 64'hFFFF_FFFF_FC18, 64'(random48()));
		random_phase(60, 50, 1'b1);
		apply_settings(64'd0, 64'd3, 64'(random48()), 64'hFFFF_FFFF_FFFF);
		random_phase(40, 50, 1'b1);
		// leave counts behind, then lower the capacity under them
		apply_settings(64'd16, 64'd8, 64'd4096, 64'd8192);
		random_phase(60, 75, 1'b0);
		apply_settings(64'd16, 64'd2, 64'd4096, 64'd8192);
		random_phase(60, 50, 1'b1);
		for (k = 0; k < 4; k++) begin
			cap = ($urandom_range(0, 3) == 0) ? 64'($urandom_range(9, 1024))
					: 64'($urandom_range(1, 8));
			apply_settings(64'($urandom_range(1, 256)), cap, 64'(random48()), 64'(random48()));
			random_phase(70, $urandom_range(35, 70), 1'b1);
		end
	endtask

	// Receiver holds off while requests keep coming, so the input stalls
	task automatic test_output_backpressure();
		apply_settings(64'd8, 64'd16, 64'(random48()), 64'(random48()));
		hold_request = 400;
		repeat (30)
			send_request(REQ_ALLOC, random48());
		wait_all_results();
		while (live_handles.size() > 0)
			send_request(REQ_FREE, take_live_handle());
		wait_all_results();
	endtask

	task automatic finish_run();
		int spins;
		s_tvalid <= 1'b0;
		spins = 0;
		while (grants_due.size() != 0 && spins < 20000) begin
			@(posedge clk);
			spins++;
		end
		repeat (40)
			@(posedge clk);
		mismatch_count += grants_due.size();
		$display("Covered %0d requests (%0d allocate, %0d release) across %0d register writes",
				alloc_sent + free_sent, alloc_sent, free_sent, reg_writes);
		$display("Grants: %0d ok, %0d exhausted, %0d stray; %0d results checked, %0d errors",
				tally_ok, tally_exhausted, tally_stray, results_checked, mismatch_count);
		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	endtask

	initial begin
		repeat (9)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_exhaustion_and_wrap();
		test_zero_stride();
		test_output_backpressure();
		test_random_settings();
		finish_run();
	end

	// Watchdog
	initial begin
		#8000000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

>>> sim.f
hw/rtl/mhba_pkg.sv
hw/rtl/mhba_ram.sv
hw/rtl/multi_heap_bump_descriptor_allocator.sv
dv/testbench.sv
